// File: hdl/mcbd_pkg.sv
// ----------------------------------------------------------------------------
// mcbd_pkg
// Shared types and codes for the multi-click button decoder.
// ----------------------------------------------------------------------------
package mcbd_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned TimeW    = 32;
    localparam int unsigned ClickW   = 4;
    localparam int unsigned EffectW  = 8;

    localparam logic [ClickW-1:0] ClickMax = '1;

    typedef enum logic [CfgIdxW-1:0] {
        REG_SETUP_HOLD  = 3'd0,
        REG_POWER_HOLD  = 3'd1,
        REG_CLICK_GAP   = 3'd2,
        REG_NEXT_CLICKS = 3'd3,
        REG_PREV_CLICKS = 3'd4,
        REG_EFFECT_CNT  = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_NEXT      = 3'd1,
        ACT_PREV      = 3'd2,
        ACT_SETUP     = 3'd3,
        ACT_POWER_OFF = 3'd4,
        ACT_POWER_ON  = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        MARK_NONE  = 2'd0,
        MARK_SETUP = 2'd1,
        MARK_POWER = 2'd2
    } t_mark;

    typedef struct packed {
        logic [15:0]        setup_hold_ms;
        logic [15:0]        power_hold_ms;
        logic [15:0]        click_gap_ms;
        logic [ClickW-1:0]  next_clicks;
        logic [ClickW-1:0]  prev_clicks;
        logic [EffectW-1:0] effect_count;
    } t_cfg;

    typedef struct packed {
        t_action            action;
        logic               power_on;
        logic [EffectW-1:0] effect_index;
        logic [ClickW-1:0]  clicks;
    } t_result;

endpackage

// File: hdl/mcbd_if.sv
// ----------------------------------------------------------------------------
// mcbd interfaces
// Valid/ready channels for button samples, decoded results and register writes.
// ----------------------------------------------------------------------------
interface mcbd_in_if;
    logic        valid;
    logic        ready;
    logic        pressed;
    logic [31:0] now_ms;

    modport source (output valid, output pressed, output now_ms, input ready);
    modport sink   (input valid, input pressed, input now_ms, output ready);
endinterface

interface mcbd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic       power_on;
    logic [7:0] effect_index;
    logic [3:0] clicks;

    modport source (output valid, output action, output power_on, output effect_index,
                    output clicks, input ready);
    modport sink   (input valid, input action, input power_on, input effect_index,
                    input clicks, output ready);
endinterface

interface mcbd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/mcbd_cfg.sv
// ----------------------------------------------------------------------------
// mcbd_cfg
// Configuration register file, written one register per word.
// ----------------------------------------------------------------------------
module mcbd_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr,
    input  logic [mcbd_pkg::CfgIdxW-1:0]    i_index,
    input  logic [mcbd_pkg::CfgDataW-1:0]   i_data,
    output mcbd_pkg::t_cfg                  o_cfg
);
    import mcbd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setup_hold_ms <= 16'd5000;
            r_cfg.power_hold_ms <= 16'd2000;
            r_cfg.click_gap_ms  <= 16'd500;
            r_cfg.next_clicks   <= ClickW'(1);
            r_cfg.prev_clicks   <= ClickW'(2);
            r_cfg.effect_count  <= EffectW'(128);
        end else if (i_wr) begin
            case (i_index)
                REG_SETUP_HOLD:  r_cfg.setup_hold_ms <= i_data;
                REG_POWER_HOLD:  r_cfg.power_hold_ms <= i_data;
                REG_CLICK_GAP:   r_cfg.click_gap_ms  <= i_data;
                REG_NEXT_CLICKS: r_cfg.next_clicks   <= i_data[ClickW-1:0];
                REG_PREV_CLICKS: r_cfg.prev_clicks   <= i_data[ClickW-1:0];
                REG_EFFECT_CNT:  r_cfg.effect_count  <= i_data[EffectW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hdl/mcbd_core.sv
// ----------------------------------------------------------------------------
// mcbd_core
// Press timing, click counting and action decode with the decoder state.
// ----------------------------------------------------------------------------
module mcbd_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_pressed,
    input  logic [mcbd_pkg::TimeW-1:0]    i_now_ms,
    input  mcbd_pkg::t_cfg                i_cfg,
    output mcbd_pkg::t_result             o_result
);
    import mcbd_pkg::*;

    logic               r_held, n_held;
    logic [TimeW-1:0]   r_press_start, n_press_start;
    logic [ClickW-1:0]  r_clicks, n_clicks;
    t_mark              r_mark, n_mark;
    logic               r_lamp_on, n_lamp_on;
    logic [EffectW-1:0] r_effect, n_effect;
    t_action            n_action;

    logic [TimeW-1:0]   delta;
    logic [EffectW:0]   wrap;
    logic [EffectW:0]   back_wrap;
    logic [EffectW:0]   fwd;
    logic [EffectW-1:0] fwd_idx;
    logic [EffectW-1:0] back_idx;

    assign delta = i_now_ms - r_press_start;
    // a zero count means the full 8-bit range
    assign wrap  = (i_cfg.effect_count == '0) ? (EffectW+1)'(1 << EffectW)
                                               : {1'b0, i_cfg.effect_count};
    assign back_wrap = wrap - (EffectW+1)'(1);
    assign fwd      = {1'b0, r_effect} + (EffectW+1)'(1);
    assign fwd_idx  = (fwd >= wrap) ? '0 : fwd[EffectW-1:0];
    assign back_idx = (r_effect == '0) ? back_wrap[EffectW-1:0] : r_effect - EffectW'(1);

    always_comb begin
        n_held        = r_held;
        n_press_start = r_press_start;
        n_clicks      = r_clicks;
        n_mark        = r_mark;
        n_lamp_on     = r_lamp_on;
        n_effect      = r_effect;
        n_action      = ACT_NONE;
        if (i_pressed) begin
            if (r_held) begin
                if (!r_lamp_on) begin
                    if (delta >= TimeW'(i_cfg.setup_hold_ms)) n_mark = MARK_SETUP;
                end else begin
                    if (delta >= TimeW'(i_cfg.power_hold_ms)) n_mark = MARK_POWER;
                end
            end else begin
                n_held        = 1'b1;
                n_press_start = i_now_ms;
            end
        end else if (r_held) begin
            n_held = 1'b0;
            if (delta <= TimeW'(i_cfg.click_gap_ms)) begin
                if (r_clicks != ClickMax) n_clicks = r_clicks + ClickW'(1);
            end else begin
                n_clicks = ClickW'(1);
            end
        end else if (delta >= TimeW'(i_cfg.click_gap_ms) && r_clicks != '0) begin
            if (r_lamp_on) begin
                if (r_mark == MARK_SETUP) begin
                    n_action = ACT_SETUP;
                end else if (r_mark == MARK_POWER) begin
                    n_lamp_on = 1'b0;
                    n_action  = ACT_POWER_OFF;
                end else if (r_clicks == i_cfg.next_clicks) begin
                    n_effect = fwd_idx;
                    n_action = ACT_NEXT;
                end else if (r_clicks == i_cfg.prev_clicks) begin
                    n_effect = back_idx;
                    n_action = ACT_PREV;
                end
            end else begin
                n_lamp_on = 1'b1;
                n_action  = ACT_POWER_ON;
            end
            n_mark   = MARK_NONE;
            n_clicks = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held        <= 1'b0;
            r_press_start <= '0;
            r_clicks      <= '0;
            r_mark        <= MARK_NONE;
            r_lamp_on     <= 1'b0;
            r_effect      <= '0;
        end else if (i_step) begin
            r_held        <= n_held;
            r_press_start <= n_press_start;
            r_clicks      <= n_clicks;
            r_mark        <= n_mark;
            r_lamp_on     <= n_lamp_on;
            r_effect      <= n_effect;
        end
    end

    assign o_result.action       = n_action;
    assign o_result.power_on     = n_lamp_on;
    assign o_result.effect_index = n_effect;
    assign o_result.clicks       = n_clicks;

`ifndef ASSERT_OFF
    a_effect_moves_on_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && n_effect != r_effect) |-> (n_action == ACT_NEXT || n_action == ACT_PREV))
        else $error("effect index changed without a next or previous action");

    a_resolve_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && n_action != ACT_NONE) |=> (r_clicks == '0 && r_mark == MARK_NONE))
        else $error("clicks or hold mark left after an action");

    a_state_holds_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_clicks) && $stable(r_lamp_on) && $stable(r_effect)))
        else $error("decoder state moved without a sample");
`endif

endmodule

// File: hdl/multi_click_button_decoder.sv
// ----------------------------------------------------------------------------
// multi_click_button_decoder
// path: an accepted sample is held in the input register, then its decode is registered in the result register
// throughput: one sample per cycle while the result register is not stalled by o_out.ready
// reset (synchronous, active low) clears both pipeline stages and the decoder state,
// and loads the register defaults; configuration writes are taken every cycle
// ----------------------------------------------------------------------------
module multi_click_button_decoder (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mcbd_in_if.sink          i_in,
    mcbd_cfg_if.sink         i_cfg,
    mcbd_out_if.source       o_out
);
    import mcbd_pkg::*;

    logic             r_in_valid;
    logic             r_pressed;
    logic [TimeW-1:0] r_now;
    logic             r_out_valid;
    t_result          r_result;

    logic    adv;
    t_cfg    cfg;
    t_result result;

    // the sample moves to the result register when that register is free or draining
    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;
    assign i_cfg.ready = 1'b1;

    mcbd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    mcbd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (adv),
        .i_pressed (r_pressed),
        .i_now_ms  (r_now),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) r_in_valid <= i_in.valid;
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_pressed <= i_in.pressed;
            r_now     <= i_in.now_ms;
        end
        if (adv) r_result <= result;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.action       = r_result.action;
    assign o_out.power_on     = r_result.power_on;
    assign o_out.effect_index = r_result.effect_index;
    assign o_out.clicks       = r_result.clicks;

`ifndef ASSERT_OFF
    a_advance_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("sample advanced but no result presented");

    a_power_on_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.action == ACT_POWER_ON) |-> r_result.power_on)
        else $error("power on action with lamp off");

    a_power_off_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.action == ACT_POWER_OFF) |-> !r_result.power_on)
        else $error("power off action with lamp on");
`endif

endmodule

// File: dv/multi_click_button_decoder_checker.sv
// ----------------------------------------------------------------------------
// multi_click_button_decoder_checker
// Watches the sample, register and result channels of the button decoder,
// keeps its own copy of the decoder state and register file, and compares
// every result word field by field against the decode of its sample.
// ----------------------------------------------------------------------------
module multi_click_button_decoder_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    mcbd_in_if   i_in,
    mcbd_cfg_if  i_cfg,
    mcbd_out_if  i_out,
    output int   o_mismatches,
    output int   o_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    import mcbd_pkg::*;

    localparam int PrintLimit = 200;

    localparam t_cfg CfgDefault = '{
        setup_hold_ms: 16'd5000,
        power_hold_ms: 16'd2000,
        click_gap_ms:  16'd500,
        next_clicks:   4'd1,
        prev_clicks:   4'd2,
        effect_count:  8'd128
    };

    t_cfg               regs;
    logic               held;
    logic [TimeW-1:0]   press_start;
    logic [ClickW-1:0]  click_total;
    logic [1:0]         mark;
    logic               lamp_on;
    logic [EffectW-1:0] effect;

    t_result decoded_results[$];
    int      mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string what);
        if (mismatch_count < PrintLimit) begin
            $display("%0t ns: decode mismatch, %s", $time, what);
        end
        mismatch_count++;
    endtask

    // one tick of the decoder, updates the shadow state
    function automatic t_result decode_sample(input logic pressed, input logic [TimeW-1:0] now);
        logic [TimeW-1:0] elapsed;
        logic [8:0]       span;
        logic [8:0]       step;
        t_result          r;
        elapsed  = now - press_start;
        span     = (regs.effect_count == '0) ? 9'd256 : {1'b0, regs.effect_count};
        r.action = ACT_NONE;
        if (pressed) begin
            if (held) begin
                if (!lamp_on) begin
                    if (elapsed >= TimeW'(regs.setup_hold_ms)) mark = MARK_SETUP;
                end else if (elapsed >= TimeW'(regs.power_hold_ms)) begin
                    mark = MARK_POWER;
                end
            end else begin
                held        = 1'b1;
                press_start = now;
            end
        end else if (held) begin
            held = 1'b0;
            if (elapsed <= TimeW'(regs.click_gap_ms)) begin
                if (click_total != ClickMax) click_total = click_total + 1'b1;
            end else begin
                click_total = ClickW'(1);
            end
        end else if (elapsed >= TimeW'(regs.click_gap_ms) && click_total != '0) begin
            if (!lamp_on) begin
                lamp_on  = 1'b1;
                r.action = ACT_POWER_ON;
            end else if (mark == MARK_SETUP) begin
                r.action = ACT_SETUP;
            end else if (mark == MARK_POWER) begin
                lamp_on  = 1'b0;
                r.action = ACT_POWER_OFF;
            end else if (click_total == regs.next_clicks) begin
                // an index at or past the count falls back to zero
                step     = {1'b0, effect} + 9'd1;
                effect   = (step >= span) ? '0 : step[EffectW-1:0];
                r.action = ACT_NEXT;
            end else if (click_total == regs.prev_clicks) begin
                step     = (effect == '0) ? span : {1'b0, effect};
                step     = step - 9'd1;
                effect   = step[EffectW-1:0];
                r.action = ACT_PREV;
            end
            mark        = MARK_NONE;
            click_total = '0;
        end
        r.power_on     = lamp_on;
        r.effect_index = effect;
        r.clicks       = click_total;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            regs        = CfgDefault;
            held        = 1'b0;
            press_start = '0;
            click_total = '0;
            mark        = MARK_NONE;
            lamp_on     = 1'b0;
            effect      = '0;
            decoded_results.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_SETUP_HOLD:  regs.setup_hold_ms = i_cfg.data;
                    REG_POWER_HOLD:  regs.power_hold_ms = i_cfg.data;
                    REG_CLICK_GAP:   regs.click_gap_ms  = i_cfg.data;
                    REG_NEXT_CLICKS: regs.next_clicks   = i_cfg.data[ClickW-1:0];
                    REG_PREV_CLICKS: regs.prev_clicks   = i_cfg.data[ClickW-1:0];
                    REG_EFFECT_CNT:  regs.effect_count  = i_cfg.data[EffectW-1:0];
                    default: ;
                endcase
            end
            // a result always comes from an earlier sample, so pop before push
            if (i_out.valid && i_out.ready) begin
                if (decoded_results.size() == 0) begin
                    report_mismatch($sformatf("result word with nothing outstanding, action %0d",
                                              i_out.action));
                end else begin
                    want = decoded_results.pop_front();
                    if (i_out.action !== want.action)
                        report_mismatch($sformatf("action got %0d expected %0d",
                                                  i_out.action, want.action));
                    if (i_out.power_on !== want.power_on)
                        report_mismatch($sformatf("power_on got %0d expected %0d",
                                                  i_out.power_on, want.power_on));
                    if (i_out.effect_index !== want.effect_index)
                        report_mismatch($sformatf("effect_index got %0d expected %0d",
                                                  i_out.effect_index, want.effect_index));
                    if (i_out.clicks !== want.clicks)
                        report_mismatch($sformatf("clicks got %0d expected %0d",
                                                  i_out.clicks, want.clicks));
                end
            end
            if (i_in.valid && i_in.ready) begin
                decoded_results.push_back(decode_sample(i_in.pressed, i_in.now_ms));
            end
        end
        o_in_flight <= decoded_results.size();
    end

endmodule

// File: dv/multi_click_button_decoder_tb.sv
// ----------------------------------------------------------------------------
// multi_click_button_decoder_tb
// Drives button samples and register writes into the decoder with random
// idle gaps and result backpressure: a directed opening for power on, next,
// previous, unmatched clicks, holds and timestamp wrap, then click gestures
// under several register settings; the checker does all comparison.
// ----------------------------------------------------------------------------
module multi_click_button_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mcbd_pkg::*;

    localparam int HalfPeriod  = 5;
    localparam int ResetCycles = 6;
    localparam int DrainCycles = 4;
    localparam int PhaseItems  = 130;
    localparam int NumPhases   = 7;

    localparam logic [CfgIdxW-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_SPARE_B = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int mismatches;
    int in_flight;

    // shaping only: thresholds used to aim timestamps near the edges
    int unsigned setup_ms = 5000;
    int unsigned power_ms = 2000;
    int unsigned gap_ms   = 500;

    logic [TimeW-1:0] clock_ms = '0;
    int               sent     = 0;
    logic             calm     = 1'b0;

    mcbd_in_if  in_ch();
    mcbd_out_if res_ch();
    mcbd_cfg_if cfg_ch();

    multi_click_button_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (res_ch)
    );

    multi_click_button_decoder_checker decode_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_cfg        (cfg_ch),
        .i_out        (res_ch),
        .o_mismatches (mismatches),
        .o_in_flight  (in_flight)
    );

    always #(HalfPeriod) i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int unsigned draw_wait();
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    // mostly small steps, some right at the threshold, a few wild jumps
    function automatic logic [TimeW-1:0] pick_adv(input int unsigned thr);
        case ($urandom_range(0, 15))
            9:       return TimeW'(thr) - 1;
            10:      return TimeW'(thr);
            11:      return TimeW'(thr) + 1;
            12, 13:  return TimeW'($urandom_range(0, 2 * thr + 2));
            14:      return TimeW'($urandom());
            default: return TimeW'($urandom_range(0, 3));
        endcase
    endfunction

    // result side: fresh stall per word
    initial begin
        int unsigned stall;
        res_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_wait();
            if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    task automatic send_sample(input logic pressed, input logic [TimeW-1:0] stamp);
        int unsigned wait_cycles;
        wait_cycles = draw_wait();
        if (wait_cycles != 0) begin
            in_ch.valid <= 1'b0;
            repeat (wait_cycles) @(posedge i_clk);
        end
        clock_ms       = stamp;
        in_ch.valid   <= 1'b1;
        in_ch.pressed <= pressed;
        in_ch.now_ms  <= stamp;
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
    endtask

    task automatic tick(input logic pressed, input logic [TimeW-1:0] adv);
        send_sample(pressed, clock_ms + adv);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
        int unsigned wait_cycles;
        wait_cycles = draw_wait();
        if (wait_cycles != 0) begin
            cfg_ch.valid <= 1'b0;
            repeat (wait_cycles) @(posedge i_clk);
        end
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (in_flight != 0);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // upper data bits of the narrow registers are junk on purpose
    task automatic set_config(input int unsigned setup, input int unsigned power,
                              input int unsigned gap, input int unsigned nxt,
                              input int unsigned prv, input int unsigned cnt);
        write_reg(REG_SETUP_HOLD, 16'(setup));
        write_reg(REG_SPARE_A, 16'($urandom()));
        write_reg(REG_POWER_HOLD, 16'(power));
        write_reg(REG_CLICK_GAP, 16'(gap));
        write_reg(REG_NEXT_CLICKS, {12'($urandom()), 4'(nxt)});
        write_reg(REG_PREV_CLICKS, {12'($urandom()), 4'(prv)});
        write_reg(REG_SPARE_B, 16'($urandom()));
        write_reg(REG_EFFECT_CNT, {8'($urandom()), 8'(cnt)});
        cfg_ch.valid <= 1'b0;
        setup_ms = setup & 16'hFFFF;
        power_ms = power & 16'hFFFF;
        gap_ms   = gap & 16'hFFFF;
        do @(posedge i_clk); while (1'b0);
    endtask

    // a burst of presses followed by idle ticks that may resolve them
    task automatic play_gesture();
        int unsigned taps;
        int unsigned holds;
        int unsigned hold_thr;
        taps     = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 18) : $urandom_range(1, 3);
        hold_thr = ($urandom_range(0, 1) != 0) ? setup_ms : power_ms;
        for (int i = 0; i < taps; i++) begin
            tick(1'b1, pick_adv(gap_ms));
            holds = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            repeat (holds) tick(1'b1, pick_adv(hold_thr));
            if ($urandom_range(0, 1) != 0) begin
                tick(1'b0, TimeW'($urandom_range(0, gap_ms)));
            end else begin
                tick(1'b0, pick_adv(gap_ms));
            end
            if ($urandom_range(0, 3) == 0) tick(1'b0, TimeW'($urandom_range(0, 3)));
        end
        repeat ($urandom_range(1, 3)) tick(1'b0, pick_adv(gap_ms));
    endtask

    initial begin
        logic [TimeW-1:0] base;
        int               target;
        in_ch.valid   <= 1'b0;
        in_ch.pressed <= 1'b0;
        in_ch.now_ms  <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= REG_SETUP_HOLD;
        cfg_ch.data   <= '0;
        i_rst_n       <= 1'b0;
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // timestamp extremes with nothing pending
        send_sample(1'b0, 32'h0000_0000);
        send_sample(1'b0, 32'hFFFF_FFFF);

        // long hold while off sets the setup mark across the wrap, still powers on
        base = 32'hFFFF_FF00;
        send_sample(1'b1, base);
        send_sample(1'b1, base + 32'd5000);
        send_sample(1'b0, base + 32'd5001);
        send_sample(1'b0, base + 32'd5600);

        // single click, idle one short of the gap then at it
        base = 32'h0000_4000;
        send_sample(1'b1, base);
        send_sample(1'b0, base + 32'd10);
        send_sample(1'b0, base + 32'd499);
        send_sample(1'b0, base + 32'd500);

        // double click, release exactly at the gap counts as short
        base = 32'h0000_8000;
        send_sample(1'b1, base);
        send_sample(1'b0, base + 32'd10);
        send_sample(1'b1, base + 32'd20);
        send_sample(1'b0, base + 32'd520);
        send_sample(1'b0, base + 32'd1020);

        // triple click matches neither count
        base = 32'h0001_0000;
        send_sample(1'b1, base);
        send_sample(1'b0, base + 32'd5);
        send_sample(1'b1, base + 32'd10);
        send_sample(1'b0, base + 32'd15);
        send_sample(1'b1, base + 32'd20);
        send_sample(1'b0, base + 32'd25);
        send_sample(1'b0, base + 32'd2000);

        // power hold while on, then power off
        base = 32'h8000_0000;
        send_sample(1'b1, base);
        send_sample(1'b1, base + 32'd2000);
        send_sample(1'b0, base + 32'd2001);
        send_sample(1'b0, base + 32'd2600);

        for (int phase = 0; phase < NumPhases; phase++) begin
            if (phase != 0) begin
                drain();
                case (phase)
                    1: set_config(0, 0, 0, 0, 0, 0);
                    2: set_config(65535, 65535, 65535, 15, 15, 255);
                    3: set_config($urandom_range(0, 40), $urandom_range(0, 40),
                                  $urandom_range(0, 20), 1, 2, 0);
                    4: set_config($urandom_range(0, 40), $urandom_range(0, 40),
                                  $urandom_range(0, 20), $urandom_range(1, 3),
                                  $urandom_range(1, 4), $urandom_range(1, 6));
                    5: begin
                        target = $urandom_range(1, 3);
                        set_config($urandom_range(0, 30), $urandom_range(0, 30),
                                   $urandom_range(0, 15), target, target,
                                   $urandom_range(1, 255));
                    end
                    default: set_config($urandom_range(0, 60), $urandom_range(0, 60),
                                        $urandom_range(0, 30), $urandom_range(0, 15),
                                        $urandom_range(0, 15), $urandom_range(0, 255));
                endcase
            end
            target = sent + PhaseItems;
            while (sent < target) begin
                if ($urandom_range(0, 5) == 0) calm = ~calm;
                if ($urandom_range(0, 9) == 0) begin
                    tick(1'($urandom_range(0, 1)), TimeW'($urandom()));
                end else begin
                    play_gesture();
                end
            end
        end

        drain();
        if (mismatches == 0 && in_flight == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
